// ----- hdl/bmpa_pkg.sv -----
// ---------------------------------------------------------------------------
// bmpa_pkg
// Shared types, codes and constants for the bitmap allocator.
// ---------------------------------------------------------------------------
package bmpa_pkg;

   // Sizes fixed by the transaction fields
   localparam int KIND_W   = 3;
   localparam int IDX_W    = 10;
   localparam int CNT_W    = 11;
   localparam int STATUS_W = 2;

   // Default capacity in bits and the reset bit count
   localparam int MAX_BITS_DEF = 1024;
   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);

   // A byte with every bit marked used
   localparam logic [7:0] BYTE_ALL_USED = 8'hFF;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_FILL  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SET   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TEST  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FIND  = 3'd4;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [IDX_W-1:0]  bit_num;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                bit_value;
      logic [IDX_W-1:0]    free_index;
   } rsp_type;

   // Controller to store strobes
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic fill;
   } store_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_FIND,
      ST_PUSH
   } state_type;

endpackage

// ----- hdl/bitmap_allocator_unit.sv -----
// ---------------------------------------------------------------------------
// bitmap_allocator_unit
// Used/free bitmap with fill, set, clear, test and find-lowest-free requests.
// ---------------------------------------------------------------------------
// The bitmap lives in a byte-wide memory with a registered read; a per-byte
// valid flag makes reset and fill (all used) take effect at once, with no
// clearing pass. Fill, out-of-range indices and unused kinds need no memory
// read; set and clear read the byte, then write it back, and test only reads
// it. Find reads one byte per cycle from byte 0, up to the first free bit or
// to the last byte below bit_count (at most MAX_BITS/8 bytes). The next
// transaction is accepted while a response is still waiting in the output
// register. A bit_count above MAX_BITS acts as MAX_BITS; csr writes are
// taken at any time and must only be issued while the unit is idle.
// ---------------------------------------------------------------------------
module bitmap_allocator_unit #(
   parameter int MAX_BITS = bmpa_pkg::MAX_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bmpa_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output bmpa_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bmpa_pkg::CNT_W-1:0]  csr_data
);
   import bmpa_pkg::*;

   localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
   localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   logic [CNT_W-1:0]  bit_count_ff, bit_count_in;
   store_ctl_type     store_ctl;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [7:0]        rd_data;

   // Bit count register
   assign csr_ready    = 1'b1;
   assign bit_count_in = (csr_valid && csr_ready) ? csr_data : bit_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= COUNT_RESET;
      end else begin
         bit_count_ff <= bit_count_in;
      end
   end

   bmpa_ctrl #(
      .MAX_BITS (MAX_BITS),
      .ADDR_W   (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .bit_count (bit_count_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .store_ctl (store_ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data)
   );

   bmpa_store #(
      .STORE_BYTES (STORE_BYTES),
      .ADDR_W      (ADDR_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule

// ----- hdl/bmpa_store.sv -----
// ---------------------------------------------------------------------------
// bmpa_store
// Byte-wide bitmap memory with registered read and per-byte valid
// flags. A byte that is not valid reads as all used, so reset and fill need
// no clearing pass.
// ---------------------------------------------------------------------------
module bmpa_store #(
   parameter int STORE_BYTES = 128,
   parameter int ADDR_W      = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bmpa_pkg::store_ctl_type  ctl,
   input  logic [ADDR_W-1:0]        rd_addr,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic [7:0]               wr_data,
   output logic [7:0]               rd_data
);
   import bmpa_pkg::*;

   logic [7:0]             mem [STORE_BYTES];
   logic [STORE_BYTES-1:0] valid_ff;
   logic [7:0]             rd_q_ff;
   logic                   rd_v_ff;

   // Valid flags: cleared by reset and by fill, set on write
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.fill) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Memory array, write port and registered read port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_q_ff <= mem[rd_addr];
         rd_v_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_v_ff ? rd_q_ff : BYTE_ALL_USED;

endmodule

// ----- hdl/bmpa_ctrl.sv -----
// ---------------------------------------------------------------------------
// bmpa_ctrl
// Request sequencer: read-modify-write for set and clear, a read for test,
// a byte walk for find, and the response register.
// ---------------------------------------------------------------------------
module bmpa_ctrl #(
   parameter int MAX_BITS    = bmpa_pkg::MAX_BITS_DEF,
   parameter int ADDR_W      = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [bmpa_pkg::CNT_W-1:0]  bit_count,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bmpa_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output bmpa_pkg::rsp_type           rsp_data,
   output bmpa_pkg::store_ctl_type     store_ctl,
   output logic [ADDR_W-1:0]           rd_addr,
   output logic [ADDR_W-1:0]           wr_addr,
   output logic [7:0]                  wr_data,
   input  logic [7:0]                  rd_data
);
   import bmpa_pkg::*;

   localparam int CAP_W = $clog2(MAX_BITS + 1);
   localparam int LW    = (CAP_W > CNT_W) ? CAP_W : CNT_W;

   state_type         state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [2:0]        bitpos_ff, bitpos_in;
   logic [ADDR_W-1:0] last_ff, last_in;
   logic [2:0]        lastbit_ff, lastbit_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [LW-1:0]     count_ext;
   logic [LW-1:0]     live;
   logic [LW-1:0]     live_m1;
   logic              accept;
   logic              is_bit_op;
   logic              in_range;
   logic              slot_free;
   logic [7:0]        mask;
   logic [7:0]        lim;
   logic [7:0]        free_bits;
   logic              hit;
   logic [2:0]        pos;
   logic              at_last;
   logic              find_done;
   rsp_type           imm_res;
   rsp_type           done_res;

   // Effective bit count, clamped to capacity
   assign count_ext = LW'(bit_count);
   assign live      = (count_ext > LW'(MAX_BITS)) ? LW'(MAX_BITS) : count_ext;
   assign live_m1   = live - LW'(1);

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign is_bit_op = (req_data.kind == KIND_SET) || (req_data.kind == KIND_CLEAR) ||
                      (req_data.kind == KIND_TEST);
   assign in_range  = LW'(req_data.bit_num) < live;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Byte scan for the lowest free bit below the count
   assign at_last   = (addr_ff == last_ff);
   assign lim       = at_last ? (BYTE_ALL_USED >> (3'd7 - lastbit_ff)) : BYTE_ALL_USED;
   assign free_bits = ~rd_data & lim;
   assign hit       = |free_bits;
   assign find_done = hit || at_last;

   always_comb begin
      pos = 3'd0;
      for (int j = 7; j >= 0; j--) begin
         if (free_bits[j]) begin
            pos = 3'(j);
         end
      end
   end

   assign mask = 8'b1 << bitpos_ff;

   // Result of a request that needs no memory access
   always_comb begin
      imm_res = '0;
      if (is_bit_op) begin
         imm_res.status = STATUS_RANGE;
      end else if (req_data.kind == KIND_FIND) begin
         imm_res.status = STATUS_NONE;
      end
   end

   // Result at the end of a memory access
   always_comb begin
      done_res = '0;
      if (state_ff == ST_MODIFY) begin
         if (kind_ff == KIND_TEST) begin
            done_res.bit_value = |(rd_data & mask);
         end
      end else if (hit) begin
         done_res.free_index = IDX_W'({addr_ff, pos});
      end else begin
         done_res.status = STATUS_NONE;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_bit_op && in_range) begin
                  state_in = ST_MODIFY;
               end else if ((req_data.kind == KIND_FIND) && (live != '0)) begin
                  state_in = ST_FIND;
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_MODIFY: begin
            state_in = slot_free ? ST_IDLE : ST_PUSH;
         end
         ST_FIND: begin
            if (find_done) begin
               state_in = slot_free ? ST_IDLE : ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath
   always_comb begin
      store_ctl    = '0;
      rd_addr      = addr_ff;
      wr_addr      = addr_ff;
      wr_data      = rd_data;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      bitpos_in    = bitpos_ff;
      last_in      = last_ff;
      lastbit_in   = lastbit_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in    = req_data.kind;
               bitpos_in  = req_data.bit_num[2:0];
               last_in    = ADDR_W'(live_m1 >> 3);
               lastbit_in = live_m1[2:0];
               res_in     = imm_res;
               store_ctl.fill = (req_data.kind == KIND_FILL);
               if (req_data.kind == KIND_FIND) begin
                  addr_in = '0;
               end else begin
                  addr_in = ADDR_W'(req_data.bit_num >> 3);
               end
               rd_addr = addr_in;
               store_ctl.rd_en = (is_bit_op && in_range) ||
                                 ((req_data.kind == KIND_FIND) && (live != '0));
            end
         end
         ST_MODIFY: begin
            if (kind_ff == KIND_SET) begin
               store_ctl.wr_en = 1'b1;
               wr_data         = rd_data | mask;
            end else if (kind_ff == KIND_CLEAR) begin
               store_ctl.wr_en = 1'b1;
               wr_data         = rd_data & ~mask;
            end
            res_in = done_res;
            if (slot_free) begin
               rsp_data_in  = done_res;
               rsp_valid_in = 1'b1;
            end
         end
         ST_FIND: begin
            if (find_done) begin
               res_in = done_res;
               if (slot_free) begin
                  rsp_data_in  = done_res;
                  rsp_valid_in = 1'b1;
               end
            end else begin
               addr_in         = addr_ff + ADDR_W'(1);
               rd_addr         = addr_in;
               store_ctl.rd_en = 1'b1;
            end
         end
         ST_PUSH: begin
            if (slot_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      addr_ff     <= addr_in;
      bitpos_ff   <= bitpos_in;
      last_ff     <= last_in;
      lastbit_ff  <= lastbit_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- verif/bitmap_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bitmap_checker
// Watches the request, response and csr channels of the bitmap allocator,
// keeps its own copy of the bitmap and bit count, predicts the response of
// every accepted request transaction and compares it field by field.
// ---------------------------------------------------------------------------
module bitmap_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  bmpa_pkg::req_type           req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  bmpa_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [bmpa_pkg::CNT_W-1:0]  csr_data,
   output int                          fail_count,
   output int                          outstanding
);
   import bmpa_pkg::*;

   localparam int STORE_BYTES = MAX_BITS_DEF / 8;

   // Shadow bitmap (1 = used) and bit count
   logic [7:0]       map_byte [STORE_BYTES];
   logic [CNT_W-1:0] bit_count;

   // Responses still owed by the unit, oldest first
   rsp_type          owed_rsp_q [$];

   int               error_cnt = 0;
   int               open_cnt  = 0;

   assign fail_count  = error_cnt;
   assign outstanding = open_cnt;

   // Apply one request to the shadow bitmap and return its response
   function automatic rsp_type bitmap_apply(req_type r);
      rsp_type     res;
      int unsigned live;
      int unsigned b;
      logic [2:0]  pos;
      logic        hit;
      res            = '0;
      res.status     = STATUS_OK;
      live           = bit_count;
      if (live > MAX_BITS_DEF) live = MAX_BITS_DEF;
      b              = r.bit_num / 8;
      pos            = r.bit_num[2:0];
      hit            = 1'b0;
      case (r.kind)
         KIND_FILL: begin
            for (int i = 0; i < STORE_BYTES; i++) map_byte[i] = BYTE_ALL_USED;
         end
         KIND_SET, KIND_CLEAR, KIND_TEST: begin
            if (r.bit_num >= live) begin
               res.status = STATUS_RANGE;
            end else if (r.kind == KIND_SET) begin
               map_byte[b][pos] = 1'b1;
            end else if (r.kind == KIND_CLEAR) begin
               map_byte[b][pos] = 1'b0;
            end else begin
               res.bit_value = map_byte[b][pos];
            end
         end
         KIND_FIND: begin
            // lowest free bit below the count, partial last byte included
            for (int i = 0; i < live && !hit; i++) begin
               if (map_byte[i / 8][i % 8] == 1'b0) begin
                  hit            = 1'b1;
                  res.free_index = IDX_W'(i);
               end
            end
            if (!hit) res.status = STATUS_NONE;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Track transactions on all three channels
   always @(posedge clock) begin
      rsp_type owed;
      if (reset) begin
         for (int i = 0; i < STORE_BYTES; i++) map_byte[i] = BYTE_ALL_USED;
         bit_count = COUNT_RESET;
         owed_rsp_q.delete();
         open_cnt <= 0;
      end else begin
         // responses first: a response never belongs to a same-edge request
         if (rsp_valid && rsp_ready) begin
            if (owed_rsp_q.size() == 0) begin
               $error("response transaction with no request pending");
               error_cnt++;
            end else begin
               owed = owed_rsp_q.pop_front();
               if (rsp_data.status !== owed.status) begin
                  $error("status: expected %0d, actual %0d", owed.status, rsp_data.status);
                  error_cnt++;
               end
               if (rsp_data.bit_value !== owed.bit_value) begin
                  $error("bit_value: expected %0d, actual %0d",
                         owed.bit_value, rsp_data.bit_value);
                  error_cnt++;
               end
               if (rsp_data.free_index !== owed.free_index) begin
                  $error("free_index: expected %0d, actual %0d",
                         owed.free_index, rsp_data.free_index);
                  error_cnt++;
               end
            end
         end
         // a request on the same edge as a csr write still sees the old count
         if (req_valid && req_ready) owed_rsp_q.push_back(bitmap_apply(req_data));
         if (csr_valid && csr_ready) bit_count = csr_data;
         open_cnt <= owed_rsp_q.size();
      end
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the bitmap allocator: a directed pass over the corner cases,
// then random request phases under several bit counts with random stalls on
// both channels. The checker beside the unit predicts and compares.
// ---------------------------------------------------------------------------
module tb;
   import bmpa_pkg::*;

   localparam int RESET_CYCLES  = 9;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = MAX_BITS_DEF / 8 + 8;

   // Request kinds with no defined action
   localparam logic [KIND_W-1:0] KIND_SPARE [3] = '{3'd5, 3'd6, 3'd7};

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_data  = '0;

   int               fail_count;
   int               outstanding;
   int               cycle_count = 0;
   int unsigned      stall_left  = 0;
   logic             idle_on     = 1'b1;
   logic [CNT_W-1:0] cur_count   = COUNT_RESET;

   always #5 clock = ~clock;

   bitmap_allocator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   bitmap_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Response back pressure in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // One request transaction, with an optional idle burst ahead of it
   task automatic send_req(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx);
      int unsigned gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {kind, idx};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Hold requests until every owed response has been taken
   task automatic wait_drained;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_count(input logic [CNT_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_count = value;
   endtask

   // Mostly in-range indices, some anywhere in the field
   function automatic logic [IDX_W-1:0] pick_index();
      int unsigned live;
      live = cur_count;
      if (live > MAX_BITS_DEF) live = MAX_BITS_DEF;
      if (live == 0 || $urandom_range(0, 7) == 0) return IDX_W'($urandom_range(0, 1023));
      return IDX_W'($urandom_range(0, live - 1));
   endfunction

   task automatic run_phase(input int n, input logic allow_idle);
      int unsigned roll;
      logic [KIND_W-1:0] kind;
      for (int k = 0; k < n; k++) begin
         if (k % 40 == 0) idle_on = allow_idle && ($urandom_range(0, 3) != 0);
         if (k == n / 2) wait_drained();
         roll = $urandom_range(0, 99);
         if (roll < 3)       kind = KIND_FILL;
         else if (roll < 5)  kind = KIND_SPARE[$urandom_range(0, 2)];
         else if (roll < 30) kind = KIND_SET;
         else if (roll < 58) kind = KIND_CLEAR;
         else if (roll < 78) kind = KIND_TEST;
         else                kind = KIND_FIND;
         send_req(kind, pick_index());
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset state: all used, full count
      send_req(KIND_TEST, 10'd0);
      send_req(KIND_FIND, 10'd0);
      send_req(KIND_CLEAR, 10'd0);
      send_req(KIND_FIND, 10'd1023);
      send_req(KIND_TEST, 10'd0);
      send_req(KIND_SET, 10'd0);
      send_req(KIND_CLEAR, 10'd1023);
      send_req(KIND_FIND, 10'd517);
      send_req(KIND_TEST, 10'd1023);
      send_req(KIND_SET, 10'd1023);
      send_req(KIND_SPARE[0], 10'd1023);
      send_req(KIND_SPARE[1], 10'd0);
      send_req(KIND_SPARE[2], 10'd682);
      send_req(KIND_CLEAR, 10'd341);
      send_req(KIND_FILL, 10'd341);
      send_req(KIND_FIND, 10'd0);

      // Partial last byte and out-of-range indices
      write_count(CNT_W'(13));
      send_req(KIND_CLEAR, 10'd12);
      send_req(KIND_FIND, 10'd0);
      send_req(KIND_SET, 10'd13);
      send_req(KIND_CLEAR, 10'd13);
      send_req(KIND_TEST, 10'd1023);
      send_req(KIND_CLEAR, 10'd8);
      send_req(KIND_FIND, 10'd0);

      // Zero count: nothing in range
      write_count(CNT_W'(0));
      send_req(KIND_TEST, 10'd0);
      send_req(KIND_FIND, 10'd0);

      // Count above capacity acts as full
      write_count(CNT_W'(2047));
      send_req(KIND_FILL, 10'd0);
      send_req(KIND_CLEAR, 10'd1023);
      send_req(KIND_FIND, 10'd0);

      // Random phases under several counts; the last one without idling
      write_count(CNT_W'(13));
      run_phase(220, 1'b1);
      write_count(CNT_W'(1));
      run_phase(120, 1'b1);
      write_count(CNT_W'(2047));
      run_phase(240, 1'b1);
      write_count(CNT_W'(0));
      run_phase(60, 1'b1);
      write_count(CNT_W'(8));
      run_phase(200, 1'b1);
      write_count(CNT_W'($urandom_range(1, 1024)));
      run_phase(260, 1'b1);
      write_count(CNT_W'(1000));
      run_phase(260, 1'b1);
      write_count(CNT_W'(1024));
      idle_on = 1'b0;
      run_phase(280, 1'b0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
